### design/rea_pkg.sv
// Package for the rectangle edge angle block: widths, CORDIC constants,
// the arctangent table and the word types passed between pipeline stages.
// No dependencies.
package rea_pkg;

  // CORDIC configuration; more than 24 stages is treated as 24
  localparam int CORDIC_STAGES   = 16;
  localparam int TABLE_LEN       = 24;
  localparam int NUM_STAGES      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int COORD_FRAC_BITS = 4;  // cancels in atan2, kept for reference

  // Datapath widths
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int XY_W     = 32;
  localparam int Z_W      = 24;
  localparam int ANGLE_W  = 16;
  localparam int PRESCALE_SHIFT = 12;
  localparam int ROUND_SHIFT    = 7;

  // Angle constants: z is radians * 2^20, output is radians * 2^13
  localparam logic signed [Z_W-1:0]     HALF_PI_Z   = 24'sd1647099;
  localparam logic signed [Z_W-1:0]     ROUND_HALF  = 24'sd64;
  localparam logic signed [ANGLE_W-1:0] PI_OUT      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_OUT = 16'sd12868;

  // Input word: corner k x at [32k +: 16], corner k y at [32k+16 +: 16]
  localparam int IN_TDATA_W  = 8 * COORD_W;
  // Output word: edge_angle, lowest_corner, second_corner, zero padded
  localparam int OUT_TDATA_W = 24;

  // Corner indices chosen by the selection stage
  typedef struct packed {
    logic [1:0] lowest;
    logic [1:0] second;
  } corner_sel_t;

  // Word carried through the CORDIC stages
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic                      bypass;        // axis or coincident case
    logic signed [ANGLE_W-1:0] bypass_angle;  // exact angle for that case
    corner_sel_t               sel;
  } cordic_word_t;

  // atan(2^-i) * 2^20, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = 24'sd823550;
      5'd1:    r = 24'sd486170;
      5'd2:    r = 24'sd256879;
      5'd3:    r = 24'sd130396;
      5'd4:    r = 24'sd65451;
      5'd5:    r = 24'sd32757;
      5'd6:    r = 24'sd16383;
      5'd7:    r = 24'sd8192;
      5'd8:    r = 24'sd4096;
      5'd9:    r = 24'sd2048;
      5'd10:   r = 24'sd1024;
      5'd11:   r = 24'sd512;
      5'd12:   r = 24'sd256;
      5'd13:   r = 24'sd128;
      5'd14:   r = 24'sd64;
      5'd15:   r = 24'sd32;
      5'd16:   r = 24'sd16;
      5'd17:   r = 24'sd8;
      5'd18:   r = 24'sd4;
      5'd19:   r = 24'sd2;
      5'd20:   r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/rectangle_edge_angle.sv
// Rectangle edge angle: four corners in, atan2 of the lower edge out.
// Depth: 4 + NUM_STAGES + 1 register stages (NUM_STAGES is CORDIC_STAGES capped at 24).
// Throughput: one word per cycle unless m_tready stalls; every stage has its own valid bit and a
// stage loads when empty or draining, so bubbles close up during stalls.
// Reset (rst, synchronous) empties the pipeline; payload is not cleared.
module rectangle_edge_angle (
  input  logic                             clk,
  input  logic                             rst,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y (16 bits each, from bit 0 up)
  input  logic [rea_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // edge_angle [15:0], lowest_corner [17:16], second_corner [19:18], zeros
  output logic [rea_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready
);

  // Stage enables and valid bits
  logic en0, en1, en2, en3, en_out;
  logic v0, v1, v2, v3;
  logic c_in_ready, c_out_valid;

  // Stage 0: input word
  logic [rea_pkg::IN_TDATA_W-1:0] in_word;
  logic [3:0][rea_pkg::COORD_W-1:0] xs;
  logic [3:0][rea_pkg::COORD_W-1:0] ys;

  // Stage 1: selected corners
  rea_pkg::corner_sel_t sel;
  rea_pkg::corner_sel_t sel1;
  logic signed [rea_pkg::COORD_W-1:0] lx, ly, sx, sy;

  // Stage 2: edge vector
  rea_pkg::corner_sel_t sel2;
  logic signed [rea_pkg::DIFF_W-1:0] dx, dy;

  // Stage 3: CORDIC start word
  rea_pkg::cordic_word_t cw_next;
  rea_pkg::cordic_word_t cw;
  rea_pkg::cordic_word_t c_out;

  // Output stage
  logic signed [rea_pkg::Z_W:0]        z_rnd;
  logic signed [rea_pkg::Z_W:0]        z_shr;
  logic signed [rea_pkg::ANGLE_W-1:0]  angle_next;
  logic [rea_pkg::OUT_TDATA_W-1:0]     m_tdata_next;

  // Ready chain from the output register back to the input
  assign en_out   = !m_tvalid || m_tready;
  assign en3      = !v3 || c_in_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign s_tready = en0;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en0)    v0       <= s_tvalid;
      if (en1)    v1       <= v0;
      if (en2)    v2       <= v1;
      if (en3)    v3       <= v2;
      if (en_out) m_tvalid <= c_out_valid;
    end
  end

  // Capture input word
  always_ff @(posedge clk) begin
    if (en0) begin
      in_word <= s_tdata;
    end
  end

  // Unpack corners
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xs[k] = in_word[2*k*rea_pkg::COORD_W +: rea_pkg::COORD_W];
      ys[k] = in_word[(2*k+1)*rea_pkg::COORD_W +: rea_pkg::COORD_W];
    end
  end

  rea_select u_select (
    .ys  (ys),
    .sel (sel)
  );

  // Stage 1: latch the two chosen corners
  always_ff @(posedge clk) begin
    if (en1) begin
      sel1 <= sel;
      lx   <= $signed(xs[sel.lowest]);
      ly   <= $signed(ys[sel.lowest]);
      sx   <= $signed(xs[sel.second]);
      sy   <= $signed(ys[sel.second]);
    end
  end

  // Stage 2: edge vector from lowest to second lowest
  always_ff @(posedge clk) begin
    if (en2) begin
      sel2 <= sel1;
      dx   <= rea_pkg::DIFF_W'(sx) - rea_pkg::DIFF_W'(lx);
      dy   <= rea_pkg::DIFF_W'(sy) - rea_pkg::DIFF_W'(ly);
    end
  end

  // Stage 3: axis cases, left half plane turn and prescale
  always_comb begin
    logic signed [rea_pkg::XY_W-1:0] ex;
    logic signed [rea_pkg::XY_W-1:0] ey;
    ex = rea_pkg::XY_W'(dx);
    ey = rea_pkg::XY_W'(dy);
    cw_next              = '0;
    cw_next.sel          = sel2;
    cw_next.bypass       = (dy == '0) || (dx == '0);
    cw_next.bypass_angle = '0;
    if (dy == '0) begin
      cw_next.bypass_angle = dx[rea_pkg::DIFF_W-1] ? rea_pkg::PI_OUT : '0;
    end else if (dx == '0) begin
      cw_next.bypass_angle = dy[rea_pkg::DIFF_W-1] ? -rea_pkg::HALF_PI_OUT
                                                   : rea_pkg::HALF_PI_OUT;
    end
    if (dx[rea_pkg::DIFF_W-1]) begin
      if (!dy[rea_pkg::DIFF_W-1]) begin
        cw_next.x = ey <<< rea_pkg::PRESCALE_SHIFT;
        cw_next.y = (-ex) <<< rea_pkg::PRESCALE_SHIFT;
        cw_next.z = rea_pkg::HALF_PI_Z;
      end else begin
        cw_next.x = (-ey) <<< rea_pkg::PRESCALE_SHIFT;
        cw_next.y = ex <<< rea_pkg::PRESCALE_SHIFT;
        cw_next.z = -rea_pkg::HALF_PI_Z;
      end
    end else begin
      cw_next.x = ex <<< rea_pkg::PRESCALE_SHIFT;
      cw_next.y = ey <<< rea_pkg::PRESCALE_SHIFT;
      cw_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cw <= cw_next;
    end
  end

  rea_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (c_in_ready),
    .in_word   (cw),
    .out_valid (c_out_valid),
    .out_ready (en_out),
    .out_word  (c_out)
  );

  // Round half up to Q3.13 and saturate to +-pi
  always_comb begin
    z_rnd = (rea_pkg::Z_W+1)'(c_out.z) + (rea_pkg::Z_W+1)'(rea_pkg::ROUND_HALF);
    z_shr = z_rnd >>> rea_pkg::ROUND_SHIFT;
    if (z_shr > (rea_pkg::Z_W+1)'(rea_pkg::PI_OUT)) begin
      angle_next = rea_pkg::PI_OUT;
    end else if (z_shr < -((rea_pkg::Z_W+1)'(rea_pkg::PI_OUT))) begin
      angle_next = -rea_pkg::PI_OUT;
    end else begin
      angle_next = z_shr[rea_pkg::ANGLE_W-1:0];
    end
    if (c_out.bypass) begin
      angle_next = c_out.bypass_angle;
    end
    m_tdata_next = '0;
    m_tdata_next[rea_pkg::ANGLE_W-1:0]              = angle_next;
    m_tdata_next[rea_pkg::ANGLE_W +: 2]             = c_out.sel.lowest;
    m_tdata_next[rea_pkg::ANGLE_W + 2 +: 2]         = c_out.sel.second;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

### design/rea_select.sv
// Corner selection: finds the corner with the smallest y and the one with
// the second smallest y, earlier corner winning ties. Uses rea_pkg.
module rea_select (
  input  logic [3:0][rea_pkg::COORD_W-1:0] ys,
  output rea_pkg::corner_sel_t             sel
);

  // Walk corners 1..3 against the running lowest and second lowest
  always_comb begin
    logic [1:0] lo;
    logic [1:0] se;
    logic       have_se;
    lo      = 2'd0;
    se      = 2'd0;
    have_se = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if ($signed(ys[i]) < $signed(ys[lo])) begin
        se      = lo;
        have_se = 1'b1;
        lo      = 2'(i);
      end else if (!have_se || ($signed(ys[i]) < $signed(ys[se]))) begin
        se      = 2'(i);
        have_se = 1'b1;
      end
    end
    sel.lowest = lo;
    sel.second = se;
  end

endmodule

### design/rea_cordic.sv
// Vectoring CORDIC pipeline: one register stage per iteration with its own
// valid bits and ready chain. Uses rea_pkg for widths, table and word type.
module rea_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rea_pkg::cordic_word_t in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rea_pkg::cordic_word_t out_word
);

  localparam int N = rea_pkg::NUM_STAGES;

  rea_pkg::cordic_word_t st   [N];
  rea_pkg::cordic_word_t step [N];
  logic [N-1:0]          vld;
  logic [N-1:0]          en;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_stage
      rea_pkg::cordic_word_t src;
      logic                  src_valid;
      logic                  next_en;

      if (g == 0) begin : g_first
        assign src       = in_word;
        assign src_valid = in_valid;
      end else begin : g_rest
        assign src       = st[g-1];
        assign src_valid = vld[g-1];
      end

      if (g == N - 1) begin : g_last
        assign next_en = out_ready;
      end else begin : g_mid
        assign next_en = en[g+1];
      end

      // Stage may load when empty or when its word moves on
      assign en[g] = !vld[g] || next_en;

      // One rotation towards y = 0; arithmetic shifts floor
      always_comb begin
        logic signed [rea_pkg::XY_W-1:0] xs;
        logic signed [rea_pkg::XY_W-1:0] ys;
        xs   = src.x >>> g;
        ys   = src.y >>> g;
        step[g] = src;
        if (!src.y[rea_pkg::XY_W-1]) begin
          step[g].x = src.x + ys;
          step[g].y = src.y - xs;
          step[g].z = src.z + rea_pkg::atan_entry(5'(g));
        end else begin
          step[g].x = src.x - ys;
          step[g].y = src.y + xs;
          step[g].z = src.z - rea_pkg::atan_entry(5'(g));
        end
      end

      // Hold valid bit
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[g] <= 1'b0;
        end else if (en[g]) begin
          vld[g] <= src_valid;
        end
      end

      // Hold payload
      always_ff @(posedge clk) begin
        if (en[g]) begin
          st[g] <= step[g];
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];
  assign out_word  = st[N-1];

endmodule

### tb/rectangle_edge_angle_test.sv
// Self-checking testbench for rectangle_edge_angle: drives corner sets, predicts
// the lowest/second-lowest corners and the CORDIC edge angle, checks every word.
// Depends on rea_pkg and rectangle_edge_angle from the design folder.
`timescale 1ns / 100ps

module rectangle_edge_angle_test;

  localparam int RUN_LIMIT    = 200000;  // cycles, several times the slowest run
  localparam int DRAIN_CYCLES = 40;      // pipeline is 21 deep
  localparam int RANDOM_SETS  = 650;
  localparam int HOLD_OFF_AT  = 150;     // results taken before the long stall
  localparam int HOLD_OFF_LEN = 400;

  typedef struct packed {
    logic signed [rea_pkg::ANGLE_W-1:0] angle;
    logic [1:0]                         lowest;
    logic [1:0]                         second;
  } edge_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic [rea_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rea_pkg::OUT_TDATA_W-1:0]  m_tdata;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;

  logic [rea_pkg::IN_TDATA_W-1:0] pending_corners[$];
  edge_result_t                   predicted_edges[$];

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   send_gap = 0;
  int   words_sent = 0;
  int   recv_stall = 0;
  int   results_taken = 0;
  int   hold_off = 0;
  int   failures = 0;
  int   cycle_count = 0;

  // atan(2^-i) scaled by 2^20
  longint arctan_z [0:23] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  rectangle_edge_angle DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Vectoring CORDIC angle of (dx, dy), radians * 8192
  function automatic logic signed [rea_pkg::ANGLE_W-1:0] cordic_angle(input longint dy,
                                                                      input longint dx);
    longint x, y, z, nx, ny, r;
    if (dy == 0) return (dx < 0) ? rea_pkg::PI_OUT : '0;
    if (dx == 0) return (dy > 0) ? rea_pkg::HALF_PI_OUT : -rea_pkg::HALF_PI_OUT;
    // fold the left half plane into the right one
    if (dx < 0) begin
      if (dy >= 0) begin
        x = dy;  y = -dx; z = longint'(rea_pkg::HALF_PI_Z);
      end else begin
        x = -dy; y = dx;  z = -longint'(rea_pkg::HALF_PI_Z);
      end
    end else begin
      x = dx; y = dy; z = 0;
    end
    x = x * 4096;
    y = y * 4096;
    for (int i = 0; i < rea_pkg::NUM_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + arctan_z[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - arctan_z[i];
      end
      x = nx;
      y = ny;
    end
    r = (z + 64) >>> 7;
    if (r > longint'(rea_pkg::PI_OUT)) r = longint'(rea_pkg::PI_OUT);
    if (r < -longint'(rea_pkg::PI_OUT)) r = -longint'(rea_pkg::PI_OUT);
    return r[rea_pkg::ANGLE_W-1:0];
  endfunction

  // Pick lowest and second-lowest corners, earliest wins ties
  function automatic edge_result_t predict_edge(input logic [rea_pkg::IN_TDATA_W-1:0] w);
    longint       xs[4], ys[4];
    int           lo, se;
    bit           have_se;
    edge_result_t res;
    for (int k = 0; k < 4; k++) begin
      xs[k] = longint'($signed(w[32*k +: 16]));
      ys[k] = longint'($signed(w[32*k+16 +: 16]));
    end
    lo = 0;
    se = 0;
    have_se = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (ys[k] < ys[lo]) begin
        se = lo;
        have_se = 1'b1;
        lo = k;
      end else if (!have_se || ys[k] < ys[se]) begin
        se = k;
        have_se = 1'b1;
      end
    end
    res.angle  = cordic_angle(ys[se] - ys[lo], xs[se] - xs[lo]);
    res.lowest = lo[1:0];
    res.second = se[1:0];
    return res;
  endfunction

  function automatic logic [rea_pkg::IN_TDATA_W-1:0] pack_corners(
    input int x0, y0, x1, y1,
    input int x2, y2, x3, y3);
    logic [rea_pkg::IN_TDATA_W-1:0] w;
    w = '0;
    w[15:0]    = x0[15:0];
    w[31:16]   = y0[15:0];
    w[47:32]   = x1[15:0];
    w[63:48]   = y1[15:0];
    w[79:64]   = x2[15:0];
    w[95:80]   = y2[15:0];
    w[111:96]  = x3[15:0];
    w[127:112] = y3[15:0];
    return w;
  endfunction

  // Corners of a rotated rectangle, from a random starting corner and in a random winding
  function automatic logic [rea_pkg::IN_TDATA_W-1:0] rectangle_corners();
    int px[4], py[4];
    int cx, cy, p, q, m, first, step, shape;
    cx = $urandom_range(0, 40000) - 20000;
    cy = $urandom_range(0, 40000) - 20000;
    m  = $urandom_range(1, 3);
    shape = $urandom_range(0, 7);
    if (shape == 0) begin
      p = $urandom_range(0, 16) - 8;
      q = $urandom_range(0, 16) - 8;
    end else if (shape == 1) begin
      p = $urandom_range(0, 4000) - 2000;
      q = 0;
    end else if (shape == 2) begin
      p = 0;
      q = $urandom_range(0, 4000) - 2000;
    end else begin
      p = $urandom_range(0, 4000) - 2000;
      q = $urandom_range(0, 4000) - 2000;
    end
    px[0] = cx;                 py[0] = cy;
    px[1] = cx + p;             py[1] = cy + q;
    px[2] = cx + p - q * m;     py[2] = cy + q + p * m;
    px[3] = cx - q * m;         py[3] = cy + p * m;
    first = $urandom_range(0, 3);
    step  = $urandom_range(0, 1) ? 1 : 3;
    return pack_corners(px[first], py[first],
                        px[(first + step) % 4], py[(first + step) % 4],
                        px[(first + 2 * step) % 4], py[(first + 2 * step) % 4],
                        px[(first + 3 * step) % 4], py[(first + 3 * step) % 4]);
  endfunction

  // Coordinates biased towards the range limits
  function automatic int extreme_coord();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // Wait per word: bursts with none, long random gaps, then mostly short
  function automatic int draw_gap(input int n);
    case ((n / 64) % 3)
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Stimulus, reset and end of run
  initial begin
    // coincident corners and full ties
    pending_corners.push_back(pack_corners(0, 0, 0, 0, 0, 0, 0, 0));
    pending_corners.push_back(pack_corners(-7, 9, -7, 9, -7, 9, -7, 9));
    // edge on the x axis, pointing right and left
    pending_corners.push_back(pack_corners(0, 0, 100, 0, 100, 50, 0, 50));
    pending_corners.push_back(pack_corners(100, 0, 0, 0, 0, 50, 100, 50));
    // vertical edge
    pending_corners.push_back(pack_corners(5, 0, 5, 10, 50, 100, 60, 200));
    // left and right half planes
    pending_corners.push_back(pack_corners(100, 0, -50, 30, 200, 300, 0, 400));
    pending_corners.push_back(pack_corners(0, 0, 50, 30, -20, 300, 30, 330));
    // full-range differences
    pending_corners.push_back(pack_corners(-32768, 32767, 32767, 32767,
                                           32767, 32767, 32767, -32768));
    pending_corners.push_back(pack_corners(-32768, -32768, 32767, 32767,
                                           0, 32767, -1, 32767));
    pending_corners.push_back(pack_corners(32767, -32768, -32768, 32767,
                                           -32768, 32767, 0, 32767));
    // almost pi, almost zero, then a 45 degree edge near the bottom of the range
    pending_corners.push_back(pack_corners(32767, -100, -32768, -99, 0, 1000, 1, 1000));
    pending_corners.push_back(pack_corners(-32768, -100, 32767, -99, 0, 1000, 1, 1000));
    pending_corners.push_back(pack_corners(0, -32768, -1, 32767, 32767, 32767, 1, -32767));
    // lowest at each index, ties for lowest and for second
    pending_corners.push_back(pack_corners(1, 5, 2, 3, 3, 3, 4, 7));
    pending_corners.push_back(pack_corners(1, 4, 2, 6, 3, 2, 4, 2));
    pending_corners.push_back(pack_corners(1, 1, 2, 0, 3, 2, 4, 0));
    pending_corners.push_back(pack_corners(8, 3, 2, 1, 3, 3, 4, 3));
    pending_corners.push_back(pack_corners(8, 0, 2, 5, 3, 5, 4, 1));
    pending_corners.push_back(pack_corners(9, 9, -9, 9, 9, 2, -9, 9));
    pending_corners.push_back(pack_corners(-1, -1, -1, -1, 32767, 32767, -32768, -32768));
    pending_corners.push_back(pack_corners(0, 6, 0, 5, 0, 4, 0, 3));
    // random part: mostly rectangles, some extremes and raw noise
    for (int n = 0; n < RANDOM_SETS; n++) begin
      case ($urandom_range(0, 19))
        0, 1:    pending_corners.push_back(pack_corners(
                   extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                   extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord()));
        2, 3, 4: pending_corners.push_back({$urandom, $urandom, $urandom, $urandom});
        default: pending_corners.push_back(rectangle_corners());
      endcase
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every word to go in and every result to come out
    while (pending_corners.size() != 0 || s_tvalid || predicted_edges.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sender: offer the next word after a drawn gap, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_corners.size() != 0) begin
        s_tdata    <= pending_corners.pop_front();
        s_tvalid   <= 1'b1;
        send_gap   <= draw_gap(words_sent);
        words_sent <= words_sent + 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: may stall after each result, once for a long stretch
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        results_taken = results_taken + 1;
        recv_stall = draw_gap(results_taken);
        if (results_taken == HOLD_OFF_AT) hold_off = HOLD_OFF_LEN;
      end
      if (hold_off > 0) begin
        hold_off = hold_off - 1;
        m_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: check each result word, predict each accepted corner set
  always @(posedge clk) begin
    edge_result_t want;
    in_taken  <= !rst && s_tvalid && s_tready;
    out_taken <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (predicted_edges.size() == 0) begin
          $error("result word with nothing pending: tdata %h", m_tdata);
          failures++;
        end else begin
          want = predicted_edges.pop_front();
          if (m_tdata[15:0] !== want.angle) begin
            $error("edge_angle: expected %0d, actual %0d",
                   want.angle, $signed(m_tdata[15:0]));
            failures++;
          end
          if (m_tdata[17:16] !== want.lowest) begin
            $error("lowest_corner: expected %0d, actual %0d", want.lowest, m_tdata[17:16]);
            failures++;
          end
          if (m_tdata[19:18] !== want.second) begin
            $error("second_corner: expected %0d, actual %0d", want.second, m_tdata[19:18]);
            failures++;
          end
          if (m_tdata[rea_pkg::OUT_TDATA_W-1:20] !== '0) begin
            $error("padding: expected 0, actual %h", m_tdata[rea_pkg::OUT_TDATA_W-1:20]);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) predicted_edges.push_back(predict_edge(s_tdata));
    end
  end

endmodule
